// ===== src/sbsm_pkg.sv =====
// Package for the serial bank-switch mapper: action and target codes,
// register select codes, state and result structs, bank helper functions.
// No dependencies.
package sbsm_pkg;

  typedef enum logic [1:0] {
    ACT_CPU_READ  = 2'd0,
    ACT_CPU_WRITE = 2'd1,
    ACT_PPU_READ  = 2'd2,
    ACT_PPU_WRITE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_CHR     = 3'd3,
    TGT_PPU     = 3'd4,
    TGT_ERROR   = 3'd5
  } target_e;

  typedef enum logic [1:0] {
    SEL_CONTROL  = 2'd0,
    SEL_CHR_LOW  = 2'd1,
    SEL_CHR_HIGH = 2'd2,
    SEL_PRG      = 2'd3
  } reg_sel_e;

  typedef enum logic [0:0] {
    CFG_PRG_BANK_COUNT = 1'b0,
    CFG_CHR_BANK_COUNT = 1'b1
  } cfg_index_e;

  localparam logic [1:0]  PRG_MODE_FIX_LOW  = 2'd2;
  localparam logic [1:0]  PRG_MODE_FIX_HIGH = 2'd3;
  localparam logic [4:0]  LOAD_EMPTY        = 5'h10;
  localparam logic [4:0]  CONTROL_RESET     = 5'h0C;
  localparam logic [4:0]  PRG_COUNT_RESET   = 5'd8;
  localparam logic [5:0]  CHR_COUNT_RESET   = 6'd0;
  localparam logic [15:0] ADDR_PRG_HIGH     = 16'hC000;
  localparam logic [15:0] ADDR_PRG_RAM      = 16'h6000;
  localparam logic [15:0] ADDR_DEAD_END     = 16'h4020;
  localparam logic [13:0] PPU_CHR_HIGH      = 14'h1000;
  localparam logic [13:0] PPU_OTHER         = 14'h2000;

  typedef struct packed {
    logic [4:0] load_shift;
    logic [4:0] control_word;
    logic [3:0] prg_low_bank;
    logic [3:0] prg_high_bank;
    logic [4:0] chr_low_bank;
    logic [4:0] chr_high_bank;
    logic       chr_low_unmapped;
    logic       chr_high_unmapped;
  } sbsm_state_t;

  typedef struct packed {
    target_e     target;
    logic [17:0] mapped_address;
    logic        write_enable;
    logic [7:0]  write_byte;
    logic        register_committed;
    logic [1:0]  mirroring_mode;
  } sbsm_result_t;

  // last PRG bank for a given bank count, count clamped to 1..16
  function automatic logic [3:0] prg_last_bank(input logic [4:0] count);
    logic [3:0] r;
    if (count == 5'd0) begin
      r = 4'd0;
    end else if (count > 5'd16) begin
      r = 4'd15;
    end else begin
      r = 4'(count - 5'd1);
    end
    return r;
  endfunction

  // effective CHR bank count: RAM counts as two, clamped to 32
  function automatic logic [5:0] chr_banks(input logic [5:0] count);
    logic [5:0] r;
    if (count == 6'd0) begin
      r = 6'd2;
    end else if (count > 6'd32) begin
      r = 6'd32;
    end else begin
      r = count;
    end
    return r;
  endfunction

endpackage

// ===== src/sbsm_xlate.sv =====
// Address translation and serial register load for one bus transaction.
// Pure combinational: current state in, result and next state out.
// Depends on sbsm_pkg.
module sbsm_xlate (
  input  logic [1:0]          action_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          write_data_i,
  input  logic [5:0]          chr_bank_count_i,
  input  sbsm_pkg::sbsm_state_t state_i,
  output sbsm_pkg::sbsm_state_t state_o,
  output sbsm_pkg::sbsm_result_t result_o
);

  logic [4:0]  shift_v;
  logic [4:0]  even_v;
  logic [5:0]  even_p1;
  logic [5:0]  chr_n;
  logic        mode4k;
  logic [1:0]  prg_mode;
  logic [13:0] ppu_addr;
  sbsm_pkg::reg_sel_e sel;

  assign shift_v  = {write_data_i[0], state_i.load_shift[4:1]};
  assign even_v   = {shift_v[4:1], 1'b0};
  assign even_p1  = {1'b0, even_v} + 6'd1;
  assign chr_n    = sbsm_pkg::chr_banks(chr_bank_count_i);
  assign mode4k   = state_i.control_word[4];
  assign prg_mode = state_i.control_word[3:2];
  assign ppu_addr = address_i[13:0];
  assign sel      = sbsm_pkg::reg_sel_e'(address_i[14:13]);

  always_comb begin
    state_o = state_i;
    result_o.target             = sbsm_pkg::TGT_NONE;
    result_o.mapped_address     = '0;
    result_o.write_enable       = 1'b0;
    result_o.write_byte         = write_data_i;
    result_o.register_committed = 1'b0;
    unique case (sbsm_pkg::action_e'(action_i))
      sbsm_pkg::ACT_CPU_READ: begin
        priority if (address_i >= sbsm_pkg::ADDR_PRG_HIGH) begin
          result_o.target         = sbsm_pkg::TGT_PRG_ROM;
          result_o.mapped_address = {state_i.prg_high_bank, address_i[13:0]};
        end else if (address_i[15]) begin
          result_o.target         = sbsm_pkg::TGT_PRG_ROM;
          result_o.mapped_address = {state_i.prg_low_bank, address_i[13:0]};
        end else if (address_i >= sbsm_pkg::ADDR_PRG_RAM) begin
          result_o.target         = sbsm_pkg::TGT_PRG_RAM;
          result_o.mapped_address = {5'd0, address_i[12:0]};
        end else begin
          result_o.target = sbsm_pkg::TGT_ERROR;
        end
      end
      sbsm_pkg::ACT_CPU_WRITE: begin
        priority if (address_i[15]) begin
          if (write_data_i[7]) begin
            state_o.load_shift = sbsm_pkg::LOAD_EMPTY;
          end else if (state_i.load_shift[0]) begin
            state_o.load_shift = sbsm_pkg::LOAD_EMPTY;
            unique case (sel)
              sbsm_pkg::SEL_CONTROL: begin
                state_o.control_word        = shift_v;
                result_o.register_committed = 1'b1;
              end
              sbsm_pkg::SEL_CHR_LOW, sbsm_pkg::SEL_CHR_HIGH: begin
                if (!mode4k) begin
                  if (sel == sbsm_pkg::SEL_CHR_HIGH) begin
                    result_o.register_committed = 1'b1;
                  end else if (even_p1 >= chr_n) begin
                    result_o.target = sbsm_pkg::TGT_ERROR;
                  end else begin
                    state_o.chr_low_bank        = even_v;
                    state_o.chr_high_bank       = even_p1[4:0];
                    state_o.chr_low_unmapped    = 1'b0;
                    state_o.chr_high_unmapped   = 1'b0;
                    result_o.register_committed = 1'b1;
                  end
                end else if (chr_bank_count_i == 6'd0) begin
                  if (sel == sbsm_pkg::SEL_CHR_LOW) begin
                    state_o.chr_low_unmapped = 1'b1;
                  end else begin
                    state_o.chr_high_unmapped = 1'b1;
                  end
                  result_o.register_committed = 1'b1;
                end else if ({1'b0, shift_v} >= chr_n) begin
                  result_o.target = sbsm_pkg::TGT_ERROR;
                end else begin
                  if (sel == sbsm_pkg::SEL_CHR_LOW) begin
                    state_o.chr_low_bank     = shift_v;
                    state_o.chr_low_unmapped = 1'b0;
                  end else begin
                    state_o.chr_high_bank     = shift_v;
                    state_o.chr_high_unmapped = 1'b0;
                  end
                  result_o.register_committed = 1'b1;
                end
              end
              sbsm_pkg::SEL_PRG: begin
                if (prg_mode == sbsm_pkg::PRG_MODE_FIX_LOW) begin
                  state_o.prg_high_bank = shift_v[3:0];
                end else if (prg_mode == sbsm_pkg::PRG_MODE_FIX_HIGH) begin
                  state_o.prg_low_bank = shift_v[3:0];
                end else begin
                  state_o.prg_low_bank  = {shift_v[3:1], 1'b0};
                  state_o.prg_high_bank = {shift_v[3:1], 1'b1};
                end
                result_o.register_committed = 1'b1;
              end
              default: ;
            endcase
          end else begin
            state_o.load_shift = shift_v;
          end
        end else if (address_i >= sbsm_pkg::ADDR_PRG_RAM) begin
          result_o.target         = sbsm_pkg::TGT_PRG_RAM;
          result_o.mapped_address = {5'd0, address_i[12:0]};
          result_o.write_enable   = 1'b1;
        end else if (address_i < sbsm_pkg::ADDR_DEAD_END) begin
          result_o.target = sbsm_pkg::TGT_ERROR;
        end else begin
          result_o.target = sbsm_pkg::TGT_NONE;
        end
      end
      default: begin
        priority if (ppu_addr < sbsm_pkg::PPU_CHR_HIGH) begin
          if (!state_i.chr_low_unmapped) begin
            result_o.target         = sbsm_pkg::TGT_CHR;
            result_o.mapped_address = {1'b0, state_i.chr_low_bank, ppu_addr[11:0]};
            result_o.write_enable   = action_i[0];
          end
        end else if (ppu_addr < sbsm_pkg::PPU_OTHER) begin
          if (!state_i.chr_high_unmapped) begin
            result_o.target         = sbsm_pkg::TGT_CHR;
            result_o.mapped_address = {1'b0, state_i.chr_high_bank, ppu_addr[11:0]};
            result_o.write_enable   = action_i[0];
          end
        end else begin
          result_o.target         = sbsm_pkg::TGT_PPU;
          result_o.mapped_address = {4'd0, ppu_addr};
          result_o.write_enable   = action_i[0];
        end
      end
    endcase
    result_o.mirroring_mode = state_o.control_word[1:0];
  end

endmodule

// ===== src/serial_bank_switch_mapper.sv =====
// Serial bank-switch mapper top level: mapper state, config registers, result register.
// Latency: result valid the cycle after the transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled; the result register refills as it drains.
// Reset: load register empty, control 0x0C, PRG banks 0 / 7, CHR banks 0 / 1 mapped,
// 8 PRG banks, CHR RAM. Depends on sbsm_pkg and sbsm_xlate.
module serial_bank_switch_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  target_o,
  output logic [17:0] mapped_address_o,
  output logic        write_enable_o,
  output logic [7:0]  write_byte_o,
  output logic        register_committed_o,
  output logic [1:0]  mirroring_mode_o
);

  sbsm_pkg::sbsm_state_t  state_q, state_d;
  sbsm_pkg::sbsm_result_t result_d, result_q;
  logic [5:0] chr_count_q;
  logic       out_valid_q;
  logic       accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  sbsm_xlate u_xlate (
    .action_i         (action_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .chr_bank_count_i (chr_count_q),
    .state_i          (state_q),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_count_q                 <= sbsm_pkg::CHR_COUNT_RESET;
      state_q.load_shift          <= sbsm_pkg::LOAD_EMPTY;
      state_q.control_word        <= sbsm_pkg::CONTROL_RESET;
      state_q.prg_low_bank        <= '0;
      state_q.prg_high_bank       <= sbsm_pkg::prg_last_bank(sbsm_pkg::PRG_COUNT_RESET);
      state_q.chr_low_bank        <= '0;
      state_q.chr_high_bank       <= 5'd1;
      state_q.chr_low_unmapped    <= 1'b0;
      state_q.chr_high_unmapped   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (sbsm_pkg::cfg_index_e'(cfg_index_i))
        sbsm_pkg::CFG_PRG_BANK_COUNT: begin
          state_q.prg_low_bank  <= '0;
          state_q.prg_high_bank <= sbsm_pkg::prg_last_bank(cfg_data_i[4:0]);
        end
        sbsm_pkg::CFG_CHR_BANK_COUNT: begin
          chr_count_q               <= cfg_data_i;
          state_q.chr_low_bank      <= '0;
          state_q.chr_high_bank     <= 5'd1;
          state_q.chr_low_unmapped  <= 1'b0;
          state_q.chr_high_unmapped <= 1'b0;
        end
        default: ;
      endcase
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign target_o             = result_q.target;
  assign mapped_address_o     = result_q.mapped_address;
  assign write_enable_o       = result_q.write_enable;
  assign write_byte_o         = result_q.write_byte;
  assign register_committed_o = result_q.register_committed;
  assign mirroring_mode_o     = result_q.mirroring_mode;

  // marker bit always somewhere in the load register
  a_load_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.load_shift != 5'd0)
    else $error("load register lost its marker");

  a_commit_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && register_committed_o |-> target_o == sbsm_pkg::TGT_NONE)
    else $error("commit with a memory target");

  a_we_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |->
      target_o != sbsm_pkg::TGT_NONE && target_o != sbsm_pkg::TGT_ERROR)
    else $error("write enable without a memory target");

  a_error_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_o == sbsm_pkg::TGT_ERROR |-> mapped_address_o == 18'd0)
    else $error("error result with nonzero address");

  a_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && result_d.register_committed && !cfg_we_i |=>
      state_q.load_shift == sbsm_pkg::LOAD_EMPTY)
    else $error("load register not cleared after commit");

endmodule
